FILE: rtl/core/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the triangle tangent basis block
// Number formats, sequencer and divider state codes, and the control and
// status groups that pass between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package ttb_pkg;

   // Q16.16 field and the full Q32.32 product / difference format.
   localparam int unsigned FieldWidth = 32;
   localparam int unsigned ProdWidth  = 64;
   localparam int unsigned FracBits   = 16;
   localparam int unsigned QuotBits   = 32;

   typedef logic signed [FieldWidth-1:0] q16_type;
   typedef logic signed [ProdWidth-1:0]  q32_type;

   // Vector geometry: three axes, tangent then bitangent components.
   localparam int unsigned AxisCount = 3;
   localparam int unsigned CompCount = 2 * AxisCount;

   typedef logic [$clog2(AxisCount)-1:0] axis_type;
   typedef logic [$clog2(CompCount)-1:0] comp_type;

   localparam comp_type CompFirstBitan = comp_type'(AxisCount);
   localparam comp_type CompLast       = comp_type'(CompCount - 1);

   // Corner counter codes.
   typedef logic [1:0] corner_type;
   localparam corner_type CornerFirst  = 2'd0;
   localparam corner_type CornerSecond = 2'd1;
   localparam corner_type CornerThird  = 2'd2;

   // Divider step counter.
   typedef logic [$clog2(QuotBits)-1:0] div_count_type;
   localparam div_count_type DivStepLast = div_count_type'(QuotBits - 1);

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MUL_A,
      SEQ_MUL_B,
      SEQ_ACC,
      SEQ_CHECK,
      SEQ_DIV_START,
      SEQ_DIV_WAIT,
      SEQ_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_PREP,
      DIV_CHECK,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // Control of the shared multiply / subtract unit.
   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_sub;
   } mac_ctrl_type;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: rtl/core/ttb_if.sv
// ----------------------------------------------------------------------------
// ttb_req_if / ttb_rsp_if: valid/ready channels of the tangent basis block
// The request channel carries one vertex per beat, the response channel one
// tangent/bitangent pair per beat.
// ----------------------------------------------------------------------------
interface ttb_req_if;
   import ttb_pkg::*;

   logic    valid;
   logic    ready;
   q16_type pos_x;
   q16_type pos_y;
   q16_type pos_z;
   q16_type tex_u;
   q16_type tex_v;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output tex_u, output tex_v, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input tex_u, input tex_v, output ready);
endinterface

interface ttb_rsp_if;
   import ttb_pkg::*;

   logic    valid;
   logic    ready;
   q16_type tangent_x;
   q16_type tangent_y;
   q16_type tangent_z;
   q16_type bitangent_x;
   q16_type bitangent_y;
   q16_type bitangent_z;
   logic    degenerate;

   modport source (output valid, output tangent_x, output tangent_y, output tangent_z,
                   output bitangent_x, output bitangent_y, output bitangent_z,
                   output degenerate, input ready);
   modport sink   (input valid, input tangent_x, input tangent_y, input tangent_z,
                   input bitangent_x, input bitangent_y, input bitangent_z,
                   input degenerate, output ready);
endinterface

FILE: rtl/core/ttb_mac.sv
// ----------------------------------------------------------------------------
// ttb_mac: shared multiply and subtract unit
// One registered 32x32 signed multiply, followed by an accumulator that can
// load the product or subtract it, forming a*b - c*d.
// ----------------------------------------------------------------------------
module ttb_mac (
   input  logic                  clock,
   input  ttb_pkg::q16_type      op_a,
   input  ttb_pkg::q16_type      op_b,
   input  ttb_pkg::mac_ctrl_type ctrl,
   output ttb_pkg::q32_type      acc
);
   import ttb_pkg::*;

   q32_type prod_ff, prod_in;
   q32_type acc_ff, acc_in;

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (ctrl.mul_en) begin
         prod_in = q32_type'(op_a) * q32_type'(op_b);
      end
      if (ctrl.acc_load) begin
         acc_in = prod_ff;
      end else if (ctrl.acc_sub) begin
         acc_in = acc_ff - prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/core/ttb_div.sv
// ----------------------------------------------------------------------------
// ttb_div: serial Q16.16 divider
// Computes num * 2^16 / den truncated toward zero and saturated to 32 bits,
// one quotient bit per cycle with a restoring 64-bit subtract.
// ----------------------------------------------------------------------------
module ttb_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ttb_pkg::q32_type        num,
   input  ttb_pkg::q32_type        den,
   output ttb_pkg::q16_type        quot,
   output ttb_pkg::div_status_type status
);
   import ttb_pkg::*;

   localparam logic [QuotBits-1:0] QuotPosLim = {1'b0, {(QuotBits-1){1'b1}}};
   localparam logic [QuotBits-1:0] QuotNegLim = {1'b1, {(QuotBits-1){1'b0}}};

   div_state_type       state_ff, state_in;
   q32_type             num_ff, num_in;
   q32_type             den_ff, den_in;
   logic [ProdWidth-1:0] rem_ff, rem_in;
   logic [ProdWidth-1:0] dmag_ff, dmag_in;
   logic [FracBits-1:0] low_ff, low_in;
   logic [QuotBits-1:0] quot_ff, quot_in;
   div_count_type       count_ff, count_in;
   logic                neg_ff, neg_in;
   logic                ovf_ff, ovf_in;
   q16_type             result_ff, result_in;
   logic                done_ff, done_in;

   always_comb begin
      logic [ProdWidth-1:0] nmag;
      logic [ProdWidth-1:0] trial;
      logic [ProdWidth:0]   diff;
      logic [QuotBits-1:0]  lim;
      logic [QuotBits-1:0]  mag;
      logic                 over;

      state_in  = state_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      dmag_in   = dmag_ff;
      low_in    = low_ff;
      quot_in   = quot_ff;
      count_in  = count_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      nmag      = num_ff[ProdWidth-1] ? (~num_ff + 1'b1) : num_ff;
      trial     = {rem_ff[ProdWidth-2:0], low_ff[FracBits-1]};
      diff      = {1'b0, trial} - {1'b0, dmag_ff};
      lim       = neg_ff ? QuotNegLim : QuotPosLim;
      mag       = (ovf_ff || (quot_ff > lim)) ? lim : quot_ff;
      over      = (rem_ff >= dmag_ff);

      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               num_in   = num;
               den_in   = den;
               state_in = DIV_PREP;
            end
         end
         DIV_PREP: begin
            dmag_in  = den_ff[ProdWidth-1] ? (~den_ff + 1'b1) : den_ff;
            rem_in   = nmag >> FracBits;
            low_in   = nmag[FracBits-1:0];
            neg_in   = num_ff[ProdWidth-1] ^ den_ff[ProdWidth-1];
            state_in = DIV_CHECK;
         end
         DIV_CHECK: begin
            // A whole-part quotient of 2^16 or more cannot fit: skip the loop.
            ovf_in   = over;
            quot_in  = '0;
            count_in = '0;
            state_in = over ? DIV_DONE : DIV_RUN;
         end
         DIV_RUN: begin
            if (!diff[ProdWidth]) begin
               rem_in  = diff[ProdWidth-1:0];
               quot_in = {quot_ff[QuotBits-2:0], 1'b1};
            end else begin
               rem_in  = trial;
               quot_in = {quot_ff[QuotBits-2:0], 1'b0};
            end
            low_in   = {low_ff[FracBits-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == DivStepLast) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            result_in = neg_ff ? q16_type'(~mag + 1'b1) : q16_type'(mag);
            done_in   = 1'b1;
            state_in  = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      dmag_ff   <= dmag_in;
      low_ff    <= low_in;
      quot_ff   <= quot_in;
      count_ff  <= count_in;
      neg_ff    <= neg_in;
      ovf_ff    <= ovf_in;
      result_ff <= result_in;
   end

   assign quot        = result_ff;
   assign status.busy = (state_ff != DIV_IDLE);
   assign status.done = done_ff;

endmodule

FILE: rtl/core/triangle_tangent_basis.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis: per-triangle tangent and bitangent from uv
// Vertices arrive one beat at a time as consecutive triangle corners, each
// with a Q16.16 position and texture coordinate. The first and second corner
// of a triangle are stored as they are accepted and give no response. The third
// corner starts the computation and holds off further request beats until it
// is finished: one shared 32x32 multiplier with a subtracting accumulator forms
// the uv determinant and the six numerators, and one serial divider produces
// each of the six Q16.16 components at one quotient bit per cycle. A component
// whose quotient saturates before the divide loop skips that loop, and a zero
// determinant skips the numerators and divides; its response then carries the
// degenerate flag and zero vectors. The output register holds a finished
// response while the block already takes the next triangle's corners. Reset
// drops any partially received triangle.
// ----------------------------------------------------------------------------
module triangle_tangent_basis (
   input logic      clock,
   input logic      reset,
   ttb_req_if.sink   req_chan,
   ttb_rsp_if.source rsp_chan
);
   import ttb_pkg::*;

   // Symmetric saturation of a position or uv delta to +/-(2^31-1).
   localparam logic signed [FieldWidth:0] DeltaMax = {2'b00, {(FieldWidth-1){1'b1}}};
   localparam logic signed [FieldWidth:0] DeltaMin = -DeltaMax;

   function automatic q16_type sat_delta(input q16_type b, input q16_type a);
      logic signed [FieldWidth:0] d;
      d = {b[FieldWidth-1], b} - {a[FieldWidth-1], a};
      if (d > DeltaMax) begin
         return DeltaMax[FieldWidth-1:0];
      end else if (d < DeltaMin) begin
         return DeltaMin[FieldWidth-1:0];
      end
      return d[FieldWidth-1:0];
   endfunction

   // Sequencer and corner bookkeeping.
   seq_state_type state_ff, state_in;
   corner_type    corner_count_ff, corner_count_in;
   logic          is_det_ff, is_det_in;
   comp_type      comp_ff, comp_in;

   // Held corners (undefined until written).
   q16_type pos0_ff [AxisCount];
   q16_type pos0_in [AxisCount];
   q16_type pos1_ff [AxisCount];
   q16_type pos1_in [AxisCount];
   q16_type tex0_ff [2];
   q16_type tex0_in [2];
   q16_type tex1_ff [2];
   q16_type tex1_in [2];

   // Edge deltas of the triangle at work.
   q16_type dp1_ff [AxisCount];
   q16_type dp1_in [AxisCount];
   q16_type dp2_ff [AxisCount];
   q16_type dp2_in [AxisCount];
   q16_type du1_ff, du1_in;
   q16_type dv1_ff, dv1_in;
   q16_type du2_ff, du2_in;
   q16_type dv2_ff, dv2_in;

   // Determinant, finished components and the output register.
   q32_type den_ff, den_in;
   logic    degen_ff, degen_in;
   q16_type vec_ff [CompCount];
   q16_type vec_in [CompCount];
   q16_type rsp_vec_ff [CompCount];
   q16_type rsp_vec_in [CompCount];
   logic    rsp_degen_ff, rsp_degen_in;
   logic    rsp_valid_ff, rsp_valid_in;

   q16_type        req_pos [AxisCount];
   logic           req_accept;
   logic           rsp_take;
   axis_type       axis;
   logic           is_tan;
   q16_type        op_a;
   q16_type        op_b;
   mac_ctrl_type   mac_ctrl;
   q32_type        acc;
   logic           div_start;
   q16_type        div_quot;
   div_status_type div_status;

   assign req_pos[0] = req_chan.pos_x;
   assign req_pos[1] = req_chan.pos_y;
   assign req_pos[2] = req_chan.pos_z;

   assign req_chan.ready = (state_ff == SEQ_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;

   // Component being worked on: tangent x, y, z then bitangent x, y, z.
   assign is_tan = (comp_ff < CompFirstBitan);
   assign axis   = is_tan ? axis_type'(comp_ff) : axis_type'(comp_ff - CompFirstBitan);

   // Operand pairs for a*b - c*d. The determinant is du1*dv2 - dv1*du2, the
   // tangent numerator dp1*dv2 - dp2*dv1 and the bitangent numerator
   // dp2*du1 - dp1*du2.
   always_comb begin
      op_a = dp1_ff[axis];
      op_b = dv2_ff;
      if (state_ff == SEQ_MUL_B) begin
         if (is_det_ff) begin
            op_a = dv1_ff;
            op_b = du2_ff;
         end else if (is_tan) begin
            op_a = dp2_ff[axis];
            op_b = dv1_ff;
         end else begin
            op_a = dp1_ff[axis];
            op_b = du2_ff;
         end
      end else begin
         if (is_det_ff) begin
            op_a = du1_ff;
            op_b = dv2_ff;
         end else if (is_tan) begin
            op_a = dp1_ff[axis];
            op_b = dv2_ff;
         end else begin
            op_a = dp2_ff[axis];
            op_b = du1_ff;
         end
      end
   end

   assign mac_ctrl.mul_en   = (state_ff == SEQ_MUL_A) || (state_ff == SEQ_MUL_B);
   assign mac_ctrl.acc_load = (state_ff == SEQ_MUL_B);
   assign mac_ctrl.acc_sub  = (state_ff == SEQ_ACC);
   assign div_start         = (state_ff == SEQ_DIV_START);

   ttb_mac u_mac (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .ctrl  (mac_ctrl),
      .acc   (acc)
   );

   ttb_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (acc),
      .den    (den_ff),
      .quot   (div_quot),
      .status (div_status)
   );

   // Next state and datapath loads.
   always_comb begin
      state_in        = state_ff;
      corner_count_in = corner_count_ff;
      is_det_in       = is_det_ff;
      comp_in         = comp_ff;
      pos0_in         = pos0_ff;
      pos1_in         = pos1_ff;
      tex0_in         = tex0_ff;
      tex1_in         = tex1_ff;
      dp1_in          = dp1_ff;
      dp2_in          = dp2_ff;
      du1_in          = du1_ff;
      dv1_in          = dv1_ff;
      du2_in          = du2_ff;
      dv2_in          = dv2_ff;
      den_in          = den_ff;
      degen_in        = degen_ff;
      vec_in          = vec_ff;
      rsp_vec_in      = rsp_vec_ff;
      rsp_degen_in    = rsp_degen_ff;
      rsp_valid_in    = rsp_take ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               if (corner_count_ff == CornerThird) begin
                  // Third corner: form all edge deltas at once and start.
                  for (int i = 0; i < AxisCount; i++) begin
                     dp1_in[i] = sat_delta(pos1_ff[i], pos0_ff[i]);
                     dp2_in[i] = sat_delta(req_pos[i], pos0_ff[i]);
                  end
                  du1_in          = sat_delta(tex1_ff[0], tex0_ff[0]);
                  dv1_in          = sat_delta(tex1_ff[1], tex0_ff[1]);
                  du2_in          = sat_delta(req_chan.tex_u, tex0_ff[0]);
                  dv2_in          = sat_delta(req_chan.tex_v, tex0_ff[1]);
                  corner_count_in = CornerFirst;
                  is_det_in       = 1'b1;
                  comp_in         = '0;
                  state_in        = SEQ_MUL_A;
               end else begin
                  if (corner_count_ff == CornerFirst) begin
                     pos0_in = req_pos;
                     tex0_in[0] = req_chan.tex_u;
                     tex0_in[1] = req_chan.tex_v;
                  end else begin
                     pos1_in = req_pos;
                     tex1_in[0] = req_chan.tex_u;
                     tex1_in[1] = req_chan.tex_v;
                  end
                  corner_count_in = corner_count_ff + 1'b1;
               end
            end
         end
         SEQ_MUL_A: begin
            state_in = SEQ_MUL_B;
         end
         SEQ_MUL_B: begin
            state_in = SEQ_ACC;
         end
         SEQ_ACC: begin
            state_in = is_det_ff ? SEQ_CHECK : SEQ_DIV_START;
         end
         SEQ_CHECK: begin
            den_in    = acc;
            is_det_in = 1'b0;
            if (acc == '0) begin
               // Zero determinant: flag it and report zero vectors.
               degen_in = 1'b1;
               for (int i = 0; i < CompCount; i++) begin
                  vec_in[i] = '0;
               end
               state_in = SEQ_DONE;
            end else begin
               degen_in = 1'b0;
               state_in = SEQ_MUL_A;
            end
         end
         SEQ_DIV_START: begin
            state_in = SEQ_DIV_WAIT;
         end
         SEQ_DIV_WAIT: begin
            if (div_status.done) begin
               vec_in[comp_ff] = div_quot;
               if (comp_ff == CompLast) begin
                  state_in = SEQ_DONE;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = SEQ_MUL_A;
               end
            end
         end
         SEQ_DONE: begin
            // Load the output register once it is free or drains this cycle.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_vec_in   = vec_ff;
               rsp_degen_in = degen_ff;
               rsp_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= SEQ_IDLE;
         corner_count_ff <= CornerFirst;
         is_det_ff       <= 1'b0;
         comp_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         corner_count_ff <= corner_count_in;
         is_det_ff       <= is_det_in;
         comp_ff         <= comp_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      pos0_ff      <= pos0_in;
      pos1_ff      <= pos1_in;
      tex0_ff      <= tex0_in;
      tex1_ff      <= tex1_in;
      dp1_ff       <= dp1_in;
      dp2_ff       <= dp2_in;
      du1_ff       <= du1_in;
      dv1_ff       <= dv1_in;
      du2_ff       <= du2_in;
      dv2_ff       <= dv2_in;
      den_ff       <= den_in;
      degen_ff     <= degen_in;
      vec_ff       <= vec_in;
      rsp_vec_ff   <= rsp_vec_in;
      rsp_degen_ff <= rsp_degen_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tangent_x   = rsp_vec_ff[0];
   assign rsp_chan.tangent_y   = rsp_vec_ff[1];
   assign rsp_chan.tangent_z   = rsp_vec_ff[2];
   assign rsp_chan.bitangent_x = rsp_vec_ff[3];
   assign rsp_chan.bitangent_y = rsp_vec_ff[4];
   assign rsp_chan.bitangent_z = rsp_vec_ff[5];
   assign rsp_chan.degenerate  = rsp_degen_ff;

`ifndef SYNTHESIS
   // A finished result must wait while the previous beat is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_DONE) && rsp_valid_ff && !rsp_chan.ready |=> (state_ff == SEQ_DONE))
      else $error("response overwritten while stalled");

   // The divider is started only when it has finished the previous quotient.
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // A quotient arrives only while the sequencer is waiting for it.
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == SEQ_DIV_WAIT))
      else $error("divider result not collected");

   // The third corner's beat starts with the determinant.
   a_third_corner_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && (corner_count_ff == CornerThird) |=> (state_ff == SEQ_MUL_A) && is_det_ff)
      else $error("third corner did not start the determinant");

   // A degenerate triangle reports zero vectors.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.degenerate |->
         (rsp_chan.tangent_x == '0) && (rsp_chan.tangent_y == '0) &&
         (rsp_chan.tangent_z == '0) && (rsp_chan.bitangent_x == '0) &&
         (rsp_chan.bitangent_y == '0) && (rsp_chan.bitangent_z == '0))
      else $error("degenerate response with non-zero vector");
`endif

endmodule
